### src/assert_macros.svh
// Assertion macros shared by the RTL of the gravity accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_CLK_NR(lbl, clk, prop, msg)
`endif
`endif

### src/igacc_pkg.sv
// Types and constants of the gravity accumulator.
`default_nettype none
package igacc_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STR   = 3'd4;

  localparam logic MODE_SPHERE = 1'b0;
  localparam logic MODE_PLANE  = 1'b1;

  localparam logic DSU_DIV  = 1'b0;
  localparam logic DSU_SQRT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] strength;
    logic        enabled;
    logic [31:0] body_mass;
  } in_word_t;

  typedef struct packed {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [17:0] dir_x;
    logic [17:0] dir_y;
    logic [17:0] dir_z;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic        op;
    logic [5:0]  steps;
    logic [63:0] rem0;
    logic [63:0] bits0;
    logic [63:0] den;
  } dsu_req_t;

endpackage
`default_nettype wire

### src/igacc_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
`default_nettype none
module igacc_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  always_ff @(posedge clk) begin
    p <= {32'b0, a} * {32'b0, b};
  end

endmodule
`default_nettype wire

### src/igacc_dsu.sv
// Shared divide and square root unit, one quotient or root bit per cycle.
`default_nettype none
module igacc_dsu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire igacc_pkg::dsu_req_t req,
  output logic                   busy,
  output logic [63:0]            res
);

  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] bits;
  logic [63:0] den;
  logic        op;
  logic [64:0] t;
  logic [64:0] sub;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    if (op == igacc_pkg::DSU_SQRT) begin
      t   = {rem[62:0], bits[63:62]};
      sub = {1'b0, res[61:0], 2'b01};
    end else begin
      t   = {rem, bits[63]};
      sub = {1'b0, den};
    end
    ge   = (t >= sub);
    diff = t - sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
      rem  <= req.rem0;
      bits <= req.bits0;
      den  <= req.den;
      op   <= req.op;
      res  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[63:0] : t[63:0];
      res  <= {res[62:0], ge};
      bits <= (op == igacc_pkg::DSU_SQRT) ? {bits[61:0], 2'b00} : {bits[62:0], 1'b0};
      cnt  <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/inverse_square_gravity_accumulator_unit.sv
// Top level of the gravity accumulator: table, sequencer and datapath.
//
//  channel  direction  handshake            payload
//  in       into       in_valid / in_stall  in_data (igacc_pkg::in_word_t)
//  out      out of     out_valid/out_stall  out_data (igacc_pkg::out_word_t)
//  cfg      into       cfg_we               cfg_index, cfg_data
//
// A load writes its slot while idle. A plane query skips the root and divide work for a zero acceleration.
// A sphere query visits every slot: it skips disabled slots and attractors at the body position,
// runs the full divide and square root work for each other enabled attractor, then finishes the sum.
// The shared divide and square root unit resolves one bit per cycle and takes most of the time.
// Reset is synchronous and clears the valid bits, registers and the sequencer.
// in_stall is high while a query is at work; a finished word waits for
// out_stall to drop before the next query can finish.
`default_nettype none
`include "assert_macros.svh"
module inverse_square_gravity_accumulator_unit #(
  parameter int MAX_ATTRACTORS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire igacc_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output igacc_pkg::out_word_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [igacc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int IW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOAD  = 5'd1;
  localparam logic [4:0] S_KPREP = 5'd2;
  localparam logic [4:0] S_SQ    = 5'd3;
  localparam logic [4:0] S_SQA   = 5'd4;
  localparam logic [4:0] S_DIVS  = 5'd5;
  localparam logic [4:0] S_DIVW  = 5'd6;
  localparam logic [4:0] S_NORM  = 5'd7;
  localparam logic [4:0] S_USQ   = 5'd8;
  localparam logic [4:0] S_USQA  = 5'd9;
  localparam logic [4:0] S_SQRTS = 5'd10;
  localparam logic [4:0] S_SQRTW = 5'd11;
  localparam logic [4:0] S_UDIVS = 5'd12;
  localparam logic [4:0] S_UDIVW = 5'd13;
  localparam logic [4:0] S_TM1   = 5'd14;
  localparam logic [4:0] S_TM1A  = 5'd15;
  localparam logic [4:0] S_TM2   = 5'd16;
  localparam logic [4:0] S_TM2A  = 5'd17;
  localparam logic [4:0] S_NEXT  = 5'd18;
  localparam logic [4:0] S_PMUL  = 5'd19;
  localparam logic [4:0] S_PMULA = 5'd20;
  localparam logic [4:0] S_FIN   = 5'd21;
  localparam logic [4:0] S_FM1   = 5'd22;
  localparam logic [4:0] S_FM1A  = 5'd23;
  localparam logic [4:0] S_FM2   = 5'd24;
  localparam logic [4:0] S_FM2A  = 5'd25;
  localparam logic [4:0] S_OUT   = 5'd26;

  logic        gravity_mode;
  logic [17:0] plane_dir [3];
  logic [31:0] plane_strength;

  logic [31:0] apx [MAX_ATTRACTORS];
  logic [31:0] apy [MAX_ATTRACTORS];
  logic [31:0] apz [MAX_ATTRACTORS];
  logic [31:0] astr [MAX_ATTRACTORS];
  logic [MAX_ATTRACTORS-1:0] av;

  logic [4:0]  state;
  logic [IW-1:0] idx;
  logic [1:0]  j;
  logic        fin;
  logic [31:0] body [3];
  logic [31:0] mass;
  logic [31:0] strn;
  logic [63:0] m [3];
  logic        neg [3];
  logic [63:0] sq;
  logic [1:0]  k;
  logic [47:0] inten;
  logic [30:0] r;
  logic [16:0] q [3];
  logic [47:0] tlo;
  logic [63:0] acc [3];
  logic [63:0] fhi;
  logic [31:0] fr [3];

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  igacc_pkg::dsu_req_t dsu_req;
  logic        dsu_busy;
  logic [63:0] dsu_res;

  logic        wr_ok;
  logic [32:0] d [3];
  logic [63:0] sh;
  logic [17:0] pmag;
  logic [63:0] ma;
  logic [63:0] f;
  logic        sat;
  logic [63:0] pterm;
  logic        big;
  logic        tiny;

  igacc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  igacc_dsu u_dsu (
    .clk  (clk),
    .rst  (rst),
    .req  (dsu_req),
    .busy (dsu_busy),
    .res  (dsu_res)
  );

  assign in_stall = (state != S_IDLE);
  assign wr_ok = ({28'b0, in_data.slot} < 32'(MAX_ATTRACTORS));

  always_comb begin
    d[0] = {apx[idx][31], apx[idx]} - {body[0][31], body[0]};
    d[1] = {apy[idx][31], apy[idx]} - {body[1][31], body[1]};
    d[2] = {apz[idx][31], apz[idx]} - {body[2][31], body[2]};
    sh   = m[j] >> k;
    pmag = plane_dir[j][17] ? 18'(-plane_dir[j]) : plane_dir[j];
    ma   = acc[j][63] ? (64'd0 - acc[j]) : acc[j];
    big  = |{m[0][63:30], m[1][63:30], m[2][63:30]};
    tiny = ~|{m[0][63:29], m[1][63:29], m[2][63:29]};
    f    = fhi + (mul_p >> 16);
    sat  = (mass != 32'd0) && (ma[63:48] != 16'd0);
    pterm = {mul_p[47:0], 16'b0} + {16'b0, tlo};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = sh[31:0];
        mul_b = sh[31:0];
      end
      S_USQ: begin
        mul_a = {2'b0, m[j][29:0]};
        mul_b = {2'b0, m[j][29:0]};
      end
      S_TM1: begin
        mul_a = inten[31:0];
        mul_b = {15'b0, q[j]};
      end
      S_TM2: begin
        mul_a = {16'b0, inten[47:32]};
        mul_b = {15'b0, q[j]};
      end
      S_PMUL: begin
        mul_a = {14'b0, pmag};
        mul_b = plane_strength;
      end
      S_FM1: begin
        mul_a = ma[47:16];
        mul_b = mass;
      end
      S_FM2: begin
        mul_a = {16'b0, ma[15:0]};
        mul_b = mass;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    dsu_req = '0;
    case (state)
      S_DIVS: begin
        dsu_req.start = 1'b1;
        dsu_req.op    = igacc_pkg::DSU_DIV;
        dsu_req.steps = 6'd48;
        dsu_req.bits0 = {strn, 32'b0};
        dsu_req.den   = sq;
      end
      S_SQRTS: begin
        dsu_req.start = 1'b1;
        dsu_req.op    = igacc_pkg::DSU_SQRT;
        dsu_req.steps = 6'd32;
        dsu_req.bits0 = sq;
      end
      S_UDIVS: begin
        dsu_req.start = 1'b1;
        dsu_req.op    = igacc_pkg::DSU_DIV;
        dsu_req.steps = 6'd17;
        dsu_req.rem0  = {1'b0, m[j][63:1]};
        dsu_req.bits0 = {m[j][0], 63'b0};
        dsu_req.den   = {33'b0, r};
      end
      default: begin
        dsu_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_mode   <= igacc_pkg::MODE_PLANE;
      plane_dir[0]   <= 18'd0;
      plane_dir[1]   <= 18'd0;
      plane_dir[2]   <= 18'h30000;
      plane_strength <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        igacc_pkg::REG_MODE:  gravity_mode   <= cfg_data[0];
        igacc_pkg::REG_DIR_X: plane_dir[0]   <= cfg_data[17:0];
        igacc_pkg::REG_DIR_Y: plane_dir[1]   <= cfg_data[17:0];
        igacc_pkg::REG_DIR_Z: plane_dir[2]   <= cfg_data[17:0];
        igacc_pkg::REG_STR:   plane_strength <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_data.kind == igacc_pkg::KIND_LOAD && wr_ok) begin
      apx[IW'(in_data.slot)]  <= in_data.pos_x;
      apy[IW'(in_data.slot)]  <= in_data.pos_y;
      apz[IW'(in_data.slot)]  <= in_data.pos_z;
      astr[IW'(in_data.slot)] <= in_data.strength;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      av        <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.kind == igacc_pkg::KIND_LOAD) begin
              if (wr_ok) begin
                av[IW'(in_data.slot)] <= in_data.enabled;
              end
            end else begin
              body[0] <= in_data.pos_x;
              body[1] <= in_data.pos_y;
              body[2] <= in_data.pos_z;
              mass    <= in_data.body_mass;
              acc[0]  <= '0;
              acc[1]  <= '0;
              acc[2]  <= '0;
              fin     <= 1'b0;
              idx     <= '0;
              j       <= 2'd0;
              state   <= (gravity_mode == igacc_pkg::MODE_SPHERE) ? S_LOAD : S_PMUL;
            end
          end
        end
        S_LOAD: begin
          if (!av[idx]) begin
            state <= S_NEXT;
          end else begin
            for (int c = 0; c < 3; c++) begin
              neg[c] <= d[c][32];
              m[c]   <= {31'b0, d[c][32] ? (33'd0 - d[c]) : d[c]};
            end
            strn  <= astr[idx];
            state <= S_KPREP;
          end
        end
        S_KPREP: begin
          if (~|{m[0], m[1], m[2]}) begin
            state <= S_NEXT;
          end else begin
            if (m[0][32] | m[1][32] | m[2][32]) begin
              k <= 2'd2;
            end else if (m[0][31] | m[1][31] | m[2][31]) begin
              k <= 2'd1;
            end else begin
              k <= 2'd0;
            end
            sq    <= '0;
            j     <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_SQA;
        S_SQA: begin
          sq <= sq + mul_p;
          if (j == 2'd2) begin
            state <= S_DIVS;
          end else begin
            j     <= j + 2'd1;
            state <= S_SQ;
          end
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (!dsu_busy) begin
            inten <= dsu_res[47:0] >> {k, 1'b0};
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (big) begin
            for (int c = 0; c < 3; c++) m[c] <= {1'b0, m[c][63:1]};
          end else if (tiny) begin
            for (int c = 0; c < 3; c++) m[c] <= {m[c][62:0], 1'b0};
          end else begin
            sq    <= '0;
            j     <= 2'd0;
            state <= S_USQ;
          end
        end
        S_USQ: state <= S_USQA;
        S_USQA: begin
          sq <= sq + mul_p;
          if (j == 2'd2) begin
            state <= S_SQRTS;
          end else begin
            j     <= j + 2'd1;
            state <= S_USQ;
          end
        end
        S_SQRTS: state <= S_SQRTW;
        S_SQRTW: begin
          if (!dsu_busy) begin
            r     <= dsu_res[30:0];
            j     <= 2'd0;
            state <= S_UDIVS;
          end
        end
        S_UDIVS: state <= S_UDIVW;
        S_UDIVW: begin
          if (!dsu_busy) begin
            q[j] <= dsu_res[16:0];
            if (j == 2'd2) begin
              j     <= 2'd0;
              state <= fin ? S_FM1 : S_TM1;
            end else begin
              j     <= j + 2'd1;
              state <= S_UDIVS;
            end
          end
        end
        S_TM1: state <= S_TM1A;
        S_TM1A: begin
          tlo   <= mul_p[63:16];
          state <= S_TM2;
        end
        S_TM2: state <= S_TM2A;
        S_TM2A: begin
          acc[j] <= neg[j] ? (acc[j] - pterm) : (acc[j] + pterm);
          if (j == 2'd2) begin
            state <= S_NEXT;
          end else begin
            j     <= j + 2'd1;
            state <= S_TM1;
          end
        end
        S_NEXT: begin
          if (idx == IW'(MAX_ATTRACTORS - 1)) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_LOAD;
          end
        end
        S_PMUL: state <= S_PMULA;
        S_PMULA: begin
          acc[j] <= plane_dir[j][17] ? (64'd0 - (mul_p >> 16)) : (mul_p >> 16);
          if (j == 2'd2) begin
            state <= S_FIN;
          end else begin
            j     <= j + 2'd1;
            state <= S_PMUL;
          end
        end
        S_FIN: begin
          fin <= 1'b1;
          j   <= 2'd0;
          for (int c = 0; c < 3; c++) begin
            neg[c] <= acc[c][63];
            m[c]   <= acc[c][63] ? (64'd0 - acc[c]) : acc[c];
          end
          if (~|{acc[0], acc[1], acc[2]}) begin
            q[0]  <= '0;
            q[1]  <= '0;
            q[2]  <= '0;
            state <= S_FM1;
          end else begin
            state <= S_NORM;
          end
        end
        S_FM1: state <= S_FM1A;
        S_FM1A: begin
          fhi   <= mul_p;
          state <= S_FM2;
        end
        S_FM2: state <= S_FM2A;
        S_FM2A: begin
          if (acc[j][63]) begin
            fr[j] <= (sat || f[63:31] != 33'd0) ? 32'h8000_0000 : 32'(64'd0 - f);
          end else begin
            fr[j] <= (sat || f[63:31] != 33'd0) ? 32'h7FFF_FFFF : f[31:0];
          end
          if (j == 2'd2) begin
            state <= S_OUT;
          end else begin
            j     <= j + 2'd1;
            state <= S_FM1;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.force_x <= fr[0];
            out_data.force_y <= fr[1];
            out_data.force_z <= fr[2];
            out_data.dir_x   <= neg[0] ? 18'(18'd0 - {1'b0, q[0]}) : {1'b0, q[0]};
            out_data.dir_y   <= neg[1] ? 18'(18'd0 - {1'b0, q[1]}) : {1'b0, q[1]};
            out_data.dir_z   <= neg[2] ? 18'(18'd0 - {1'b0, q[2]}) : {1'b0, q[2]};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK_NR(a_reset_idle, clk, rst |=> (state == S_IDLE) && !out_valid, "reset left work")
  `ASSERT_CLK(a_out_wait, clk, rst, (state == S_OUT) && out_valid && out_stall |=> state == S_OUT, "word lost")
  `ASSERT_CLK(a_dsu_free, clk, rst, dsu_req.start |-> !dsu_busy, "divide unit restarted while busy")
  `ASSERT_CLK(a_root_range, clk, rst, state == S_UDIVS |-> r[30:29] != 2'b00, "root not normalized")

endmodule
`default_nettype wire
